FILE: rtl/pli_pkg.sv
package pli_pkg;

  // Operation codes of an input word
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_KEYS_DEC = 2'd1;
  localparam logic [1:0] STATUS_ZERO_SEG = 2'd2;

  // Divider shape: quotient bits kept, and bits retired per stage
  localparam int QBITS      = 36;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = QBITS / DIV_STEPS;

  // Word travelling down the divider chain
  typedef struct packed {
    logic [1:0]        status;
    logic              neg;
    logic              ovf;
    logic [31:0]       v0;
    logic [31:0]       dk;
    logic [31:0]       rem;
    logic [QBITS-1:0]  low;
    logic [QBITS-1:0]  quo;
  } div_t;

endpackage

FILE: rtl/piecewise_linear_interpolator_core.sv
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// Stages: input, segment search, table read and differences, multiply,
// nine 4-bit divider stages, round and saturate into the output register.
// Reset clears the breakpoint table to zero, point_count to 2, all valids.
module piecewise_linear_interpolator_core #(
  parameter int MAX_POINTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [2:0]         point_index_i,
  input  logic signed [31:0] point_key_i,
  input  logic signed [31:0] point_value_i,
  input  logic signed [31:0] x_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] result_value_o,
  output logic [1:0]         status_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pli_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);

  logic adv;

  // Configuration register
  logic [3:0] pc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 4'd2;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      pc_q <= pwdata[3:0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, pc_q} : 32'd0;

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Stage 1: input register
  logic               s1_valid_q;
  logic               s1_op_q;
  logic [2:0]         s1_idx_q;
  logic signed [31:0] s1_key_q, s1_val_q, s1_x_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q  <= op_i;
      s1_idx_q <= point_index_i;
      s1_key_q <= point_key_i;
      s1_val_q <= point_value_i;
      s1_x_q   <= x_value_i;
    end
  end

  // Breakpoint table, written as a write word leaves stage 1
  logic signed [31:0] key_q [MAX_POINTS];
  logic signed [31:0] val_q [MAX_POINTS];
  logic               tbl_we;
  assign tbl_we = adv && s1_valid_q && s1_op_q == OP_WRITE
                  && 32'(s1_idx_q) < 32'(MAX_POINTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_POINTS; i++) begin
        key_q[i] <= '0;
        val_q[i] <= '0;
      end
    end else if (tbl_we) begin
      key_q[IDX_W'(s1_idx_q)] <= s1_key_q;
      val_q[IDX_W'(s1_idx_q)] <= s1_val_q;
    end
  end

  // Segment search and key order check
  int             n_eff;
  logic           found, dec;
  logic [IDX_W-1:0] first, seg;
  always_comb begin
    n_eff = int'(pc_q);
    if (n_eff < 2) n_eff = 2;
    if (n_eff > MAX_POINTS) n_eff = MAX_POINTS;
    found = 1'b0;
    first = '0;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (i < n_eff && key_q[i] >= s1_x_q) begin
        found = 1'b1;
        first = IDX_W'(i);
      end
    end
    dec = 1'b0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      if (i < n_eff && key_q[i] < key_q[i-1]) dec = 1'b1;
    end
    if (!found) begin
      seg = IDX_W'(n_eff - 2);
    end else if (first == '0) begin
      seg = '0;
    end else begin
      seg = first - IDX_W'(1);
    end
  end

  // Stage 2
  logic               s2_valid_q, s2_op_q, s2_dec_q;
  logic [IDX_W-1:0]   s2_seg_q;
  logic signed [31:0] s2_x_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_op_q  <= s1_op_q;
      s2_dec_q <= dec;
      s2_seg_q <= seg;
      s2_x_q   <= s1_x_q;
    end
  end

  // Table read and differences
  logic signed [31:0] k0, k1, v0, v1;
  logic [32:0]        dk, dv, dx, adv_v, adx_v;
  logic [1:0]         st2;
  logic               neg2;
  always_comb begin
    k0 = key_q[s2_seg_q];
    k1 = key_q[s2_seg_q + IDX_W'(1)];
    v0 = val_q[s2_seg_q];
    v1 = val_q[s2_seg_q + IDX_W'(1)];
    dk = {k1[31], k1} - {k0[31], k0};
    dv = {v1[31], v1} - {v0[31], v0};
    dx = {s2_x_q[31], s2_x_q} - {k0[31], k0};
    neg2  = dv[32] ^ dx[32];
    adv_v = dv[32] ? -dv : dv;
    adx_v = dx[32] ? -dx : dx;
    if (s2_op_q == OP_WRITE) begin
      st2 = STATUS_OK;
    end else if (s2_dec_q) begin
      st2 = STATUS_KEYS_DEC;
    end else if (dk[32] || dk == 33'd0) begin
      st2 = STATUS_ZERO_SEG;
    end else begin
      st2 = STATUS_OK;
    end
  end

  // Stage 3; write words carry a null product so they finish as zero
  logic        s3_valid_q, s3_neg_q;
  logic [1:0]  s3_status_q;
  logic [31:0] s3_mdv_q, s3_mdx_q, s3_dk_q, s3_v0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_status_q <= st2;
      s3_neg_q    <= neg2;
      s3_mdv_q    <= (s2_op_q == OP_WRITE) ? 32'd0 : adv_v[31:0];
      s3_mdx_q    <= adx_v[31:0];
      s3_dk_q     <= (s2_op_q == OP_WRITE) ? 32'd1 : dk[31:0];
      s3_v0_q     <= (s2_op_q == OP_WRITE) ? 32'd0 : v0;
    end
  end

  // Stage 4: product of magnitudes
  logic        s4_valid_q, s4_neg_q;
  logic [1:0]  s4_status_q;
  logic [31:0] s4_dk_q, s4_v0_q;
  logic [63:0] s4_num_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= s3_valid_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_status_q <= s3_status_q;
      s4_neg_q    <= s3_neg_q;
      s4_dk_q     <= s3_dk_q;
      s4_v0_q     <= s3_v0_q;
      s4_num_q    <= {32'd0, s3_mdv_q} * {32'd0, s3_mdx_q};
    end
  end

  // Divider chain; quotients of 2^QBITS or more saturate anyway
  div_t chain   [DIV_STAGES+1];
  logic chain_v [DIV_STAGES+1];
  always_comb begin
    chain[0].status = s4_status_q;
    chain[0].neg    = s4_neg_q;
    chain[0].v0     = s4_v0_q;
    chain[0].dk     = s4_dk_q;
    chain[0].rem    = 32'(s4_num_q[63:QBITS]);
    chain[0].ovf    = 32'(s4_num_q[63:QBITS]) >= s4_dk_q;
    chain[0].low    = s4_num_q[QBITS-1:0];
    chain[0].quo    = '0;
  end
  assign chain_v[0] = s4_valid_q;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pli_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (chain_v[g]),
      .d_i     (chain[g]),
      .valid_o (chain_v[g+1]),
      .d_o     (chain[g+1])
    );
  end

  // Round half away from zero, apply sign, saturate
  div_t               fin;
  logic               up;
  logic [QBITS:0]     q1;
  logic signed [QBITS+1:0] res_w;
  logic signed [31:0] res;
  always_comb begin
    fin   = chain[DIV_STAGES];
    up    = fin.rem >= (fin.dk - fin.rem);
    q1    = {1'b0, fin.quo} + (QBITS+1)'(up);
    res_w = '0;
    if (fin.status != STATUS_OK) begin
      res = '0;
    end else if (fin.ovf || q1 > (QBITS+1)'(64'h4_0000_0000)) begin
      res = fin.neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      if (fin.neg) begin
        res_w = (QBITS+2)'(signed'(fin.v0)) - signed'({1'b0, q1});
      end else begin
        res_w = (QBITS+2)'(signed'(fin.v0)) + signed'({1'b0, q1});
      end
      if (res_w > (QBITS+2)'(64'sh7fff_ffff)) begin
        res = 32'sh7fff_ffff;
      end else if (res_w < -(QBITS+2)'(64'sh8000_0000)) begin
        res = 32'sh8000_0000;
      end else begin
        res = res_w[31:0];
      end
    end
  end

  // Output register
  logic               out_valid_q;
  logic signed [31:0] out_res_q;
  logic [1:0]         out_status_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain_v[DIV_STAGES];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q    <= res;
      out_status_q <= fin.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_status_q;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STATUS_OK |-> result_value_o == 32'sd0)
    else $error("error word carries a nonzero result");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_x_q))
    else $error("stage 1 word lost during stall");

  a_no_write_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> s1_valid_q && adv)
    else $error("table written without a moving write word");
`endif

endmodule

FILE: rtl/pli_div_stage.sv
module pli_div_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pli_pkg::div_t d_i,
  output logic          valid_o,
  output pli_pkg::div_t d_o
);
  import pli_pkg::*;

  logic  valid_q;
  div_t  d_q;
  div_t  d_d;
  logic [32:0] trial;

  // Restoring division, DIV_STEPS quotient bits per stage
  always_comb begin
    d_d   = d_i;
    trial = '0;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {d_d.rem, d_d.low[QBITS-1]};
      d_d.low = {d_d.low[QBITS-2:0], 1'b0};
      if (trial >= {1'b0, d_d.dk}) begin
        d_d.rem = 32'(trial - {1'b0, d_d.dk});
        d_d.quo = {d_d.quo[QBITS-2:0], 1'b1};
      end else begin
        d_d.rem = trial[31:0];
        d_d.quo = {d_d.quo[QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pli_pkg::*;

  // Breakpoint table model plus queue of expected result words
  class interp_scoreboard;
    typedef struct {
      logic signed [31:0] value;
      logic [1:0]         status;
    } interp_word_t;

    logic signed [31:0] key_tab[8];
    logic signed [31:0] val_tab[8];
    logic [3:0]         n_points;
    interp_word_t       expected_q[$];
    int                 mismatches;

    function new();
      foreach (key_tab[i]) begin
        key_tab[i] = '0;
        val_tab[i] = '0;
      end
      n_points   = 4'd2;
      mismatches = 0;
    endfunction

    function void set_count(logic [3:0] cnt);
      n_points = cnt;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Note an accepted input word and queue the result it should give
    function void note_input(logic op, logic [2:0] idx, logic signed [31:0] key,
                             logic signed [31:0] val, logic signed [31:0] x);
      interp_word_t       w;
      int                 n, seg;
      bit                 found;
      longint             k0, k1, v0, v1, dk, dv, dx, xl, res;
      longint unsigned    num, q, r, dku, mdv, mdx;
      bit                 neg;
      w.value  = '0;
      w.status = STATUS_OK;
      if (op == OP_WRITE) begin
        key_tab[idx] = key;
        val_tab[idx] = val;
        expected_q.push_back(w);
        return;
      end
      n = n_points;
      if (n < 2) n = 2;
      if (n > 8) n = 8;
      for (int i = 1; i < n; i++) begin
        if (key_tab[i] < key_tab[i-1]) w.status = STATUS_KEYS_DEC;
      end
      if (w.status == STATUS_OK) begin
        xl    = longint'(x);
        seg   = n - 2;
        found = 0;
        for (int i = 0; i < n; i++) begin
          if (!found && longint'(key_tab[i]) >= xl) begin
            seg   = (i == 0) ? 0 : i - 1;
            found = 1;
          end
        end
        k0 = longint'(key_tab[seg]);
        k1 = longint'(key_tab[seg+1]);
        v0 = longint'(val_tab[seg]);
        v1 = longint'(val_tab[seg+1]);
        dk = k1 - k0;
        if (dk <= 0) begin
          w.status = STATUS_ZERO_SEG;
        end else begin
          dv  = v1 - v0;
          dx  = xl - k0;
          neg = (dv < 0) != (dx < 0);
          mdv = (dv < 0) ? -dv : dv;
          mdx = (dx < 0) ? -dx : dx;
          num = mdv * mdx;
          dku = dk;
          q   = num / dku;
          r   = num % dku;
          // round to nearest, ties away from zero
          if (r >= dku - r) q++;
          if (q > (64'd1 << 34)) begin
            res = neg ? -64'sd2147483648 : 64'sd2147483647;
          end else begin
            res = neg ? v0 - longint'(q) : v0 + longint'(q);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
          end
          w.value = res[31:0];
        end
      end
      expected_q.push_back(w);
    endfunction

    // Compare a result word against the oldest expectation
    function void check_result(logic signed [31:0] value, logic [1:0] status);
      interp_word_t w;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word value=%0d status=%0d", value, status);
        return;
      end
      w = expected_q.pop_front();
      if (value !== w.value || status !== w.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
                   w.value, w.status, value, status);
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [3:0] SWEEP_COUNTS [7] = '{4'd8, 4'd0, 4'd1, 4'd15, 4'd9, 4'd2, 4'd5};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               op_i = OP_WRITE;
  logic [2:0]         point_index_i = '0;
  logic signed [31:0] point_key_i = '0;
  logic signed [31:0] point_value_i = '0;
  logic signed [31:0] x_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] result_value_o;
  logic [1:0]         status_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  interp_scoreboard sb = new();
  int  burst_left = 0;
  bit  hold_req = 0;
  int  cycles = 0;

  piecewise_linear_interpolator_core u_top (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: check every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(result_value_o, status_o);
  end

  // Receiver stall pattern, with an occasional long hold-off
  initial begin
    int mode;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end else begin
        if ($urandom_range(0, 63) == 0) mode = int'($urandom_range(0, 3));
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          2: out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one word, in bursts separated by random gaps
  task automatic send(logic op, logic [2:0] idx, logic signed [31:0] key,
                      logic signed [31:0] val, logic signed [31:0] x);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    op_i          <= op;
    point_index_i <= idx;
    point_key_i   <= key;
    point_value_i <= val;
    x_value_i     <= x;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(op, idx, key, val, x);
  endtask

  task automatic wr_point(logic [2:0] idx, logic signed [31:0] key, logic signed [31:0] val);
    send(OP_WRITE, idx, key, val, $urandom);
  endtask

  task automatic eval_at(logic signed [31:0] x);
    send(OP_EVAL, 3'($urandom), $urandom, $urandom, x);
  endtask

  // Stop offering and wait for every outstanding word
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // APB write of point_count; the block is idle here
  task automatic set_count(logic [3:0] cnt);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 2'd0;
    pwdata  <= {$urandom} & 32'hFFFF_FFF0 | cnt;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_count(cnt);
  endtask

  // One table load followed by a run of evaluations
  task automatic random_phase(int n_evals, bit sorted);
    int          n;
    int          keys[$];
    logic [31:0] span;
    n = sb.n_points;
    if (n < 2) n = 2;
    if (n > 8) n = 8;
    span = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : ($urandom_range(0, 1) ? 32'hFF : 32'h3FFFF);
    for (int i = 0; i < 8; i++) keys.push_back(int'($urandom & span) - int'(span >> 1));
    if ($urandom_range(0, 3) == 0) keys[1] = keys[2];
    if (sorted) keys.sort();
    for (int i = 0; i < 8; i++) begin
      if (i < n || $urandom_range(0, 3) == 0) wr_point(3'(i), keys[i], $urandom);
    end
    for (int j = 0; j < n_evals; j++) begin
      case ($urandom_range(0, 4))
        0: eval_at($urandom);
        1: eval_at(keys[$urandom_range(0, n-1)]);
        2: eval_at(keys[$urandom_range(0, n-1)] + $urandom_range(0, 8) - 4);
        3: eval_at(int'($urandom & span) - int'(span >> 1));
        default: begin
          if ($urandom_range(0, 5) == 0) wr_point(3'($urandom), $urandom, $urandom);
          else eval_at(keys[0] + $urandom_range(0, 1000) - 500);
        end
      endcase
    end
  endtask

  initial begin
    logic [3:0] cnt;
    int         sent;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table gives a zero-width segment
    eval_at(32'sd0);
    // widest segment, extreme keys and values
    wr_point(3'd0, 32'h8000_0000, 32'h8000_0000);
    wr_point(3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(32'sd0);
    eval_at(32'h8000_0000);
    eval_at(32'h7FFF_FFFF);
    eval_at(32'sd12345);
    // decreasing keys
    wr_point(3'd0, 32'sd5, 32'sd7);
    wr_point(3'd1, 32'sd3, 32'sd9);
    eval_at(32'sd4);
    // steep segment, extrapolation that saturates both ways
    wr_point(3'd0, 32'sd0, 32'sd0);
    wr_point(3'd1, 32'sd1, 32'h7FFF_FFFF);
    eval_at(32'h7FFF_FFFF);
    eval_at(32'h8000_0000);
    // rounding ties
    wr_point(3'd1, 32'sd2, 32'sd1);
    eval_at(32'sd1);
    eval_at(-32'sd1);
    // upper slots
    for (int i = 2; i < 8; i++) wr_point(3'(i), 32'h7FFF_FFFF - i, -i);
    eval_at(32'sd3);
    drain();

    // Configuration sweep with extremes and out-of-range counts
    sent = 0;
    for (int i = 0; i < 7; i++) begin
      cnt = SWEEP_COUNTS[i];
      set_count(cnt);
      random_phase(40, 1);
      drain();
    end

    // Long receiver hold-off while words keep coming
    hold_req = 1;
    random_phase(80, 1);
    drain();

    // Random phases, mostly sorted tables
    while (sent < 1200) begin
      if ($urandom_range(0, 2) == 0) begin
        drain();
        set_count(4'($urandom));
      end
      random_phase(30, $urandom_range(0, 7) != 0);
      sent += 40;
      if ($urandom_range(0, 3) == 0) drain();
    end
    drain();
    repeat (30) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/pli_pkg.sv
rtl/pli_div_stage.sv
rtl/piecewise_linear_interpolator_core.sv
tb/testbench.sv
